/* rtl/core/mafh_pkg.sv */
// ----------------------------------------------------------------------------
// mafh_pkg
// Shared constants, types and lookup tables for the MPEG audio frame header
// decoder pipeline.
// ----------------------------------------------------------------------------
package mafh_pkg;

  // Field widths.
  localparam int KBPS_W   = 9;   // kbit/s, up to 448
  localparam int KMUL_W   = 18;  // k * 1000, up to 144000
  localparam int RATE_W   = 16;  // sample rate in Hz
  localparam int RECIP_W  = 20;  // floor(2^32 / rate), up to 536870
  localparam int NUM_W    = 26;  // k * bitrate, up to 64512000
  localparam int BPS_W    = 19;  // bitrate in bit/s
  localparam int FRAME_W  = 11;  // frame length in bytes
  localparam int SPF_W    = 11;  // samples per frame
  localparam int QPROD_W  = NUM_W + RECIP_W;
  localparam int RECIP_SH = 32;  // scale of the reciprocal table
  localparam int QR_W     = FRAME_W + RATE_W;

  // Register stages from input to output.
  localparam int NSTAGE = 5;

  // Sync pattern in bits 31..21.
  localparam logic [10:0] SYNC_WORD = 11'h7FF;

  // Version codes.
  localparam logic [1:0] VER_MPEG25 = 2'd0;
  localparam logic [1:0] VER_RSV    = 2'd1;
  localparam logic [1:0] VER_MPEG2  = 2'd2;
  localparam logic [1:0] VER_MPEG1  = 2'd3;

  // Layer codes as they appear in the header.
  localparam logic [1:0] LAY_RSV = 2'd0;
  localparam logic [1:0] LAY_3   = 2'd1;
  localparam logic [1:0] LAY_2   = 2'd2;
  localparam logic [1:0] LAY_1   = 2'd3;

  // Channel mode for a single channel.
  localparam logic [1:0] MODE_MONO = 2'd3;

  // Bitrate table in kbit/s, rows: V1 L1, V1 L2, V1 L3, V2 L1, V2 L2/L3.
  localparam logic [KBPS_W-1:0] KBPS_TAB [0:4][0:15] = '{
    '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
      9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
    '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
    '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
      9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0},
    '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
    '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
      9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
  };

  // Decoded fields that ride along the pipeline unchanged.
  typedef struct packed {
    logic              hdr_ok;
    logic [1:0]        version_code;
    logic [1:0]        layer_number;
    logic [RATE_W-1:0] sample_rate_hz;
    logic [SPF_W-1:0]  pcm_samples;
    logic [1:0]        channel_count;
    logic [2:0]        header_bytes;
    logic [1:0]        channel_mode;
    logic [2:0]        flag_bits;
    logic [1:0]        emphasis_code;
  } info_t;

  // First-stage result handed to the frame length datapath.
  typedef struct packed {
    info_t              info;
    logic [KBPS_W-1:0]  kbps;
    logic [KMUL_W-1:0]  kmul;
    logic [RATE_W-1:0]  rate;
    logic [RECIP_W-1:0] recip;
    logic [2:0]         padb;
    logic               frame_ok;
  } dec_t;

  // Per-stage load enables.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } ctl_t;

  // Bitrate in kbit/s; zero for a reserved version or layer.
  function automatic logic [KBPS_W-1:0] kbps_lookup(input logic [1:0] ver,
                                                    input logic [1:0] lay,
                                                    input logic [3:0] bri);
    logic [KBPS_W-1:0] val;
    val = '0;
    if (ver != VER_RSV && lay != LAY_RSV) begin
      if (ver == VER_MPEG1) begin
        unique case (lay)
          LAY_1:   val = KBPS_TAB[0][bri];
          LAY_2:   val = KBPS_TAB[1][bri];
          default: val = KBPS_TAB[2][bri];
        endcase
      end else if (lay == LAY_1) begin
        val = KBPS_TAB[3][bri];
      end else begin
        val = KBPS_TAB[4][bri];
      end
    end
    return val;
  endfunction

  // Sample rate in Hz; zero when version or rate index is reserved.
  function automatic logic [RATE_W-1:0] rate_lookup(input logic [1:0] ver,
                                                    input logic [1:0] sri);
    logic [RATE_W-1:0] val;
    val = '0;
    unique case (ver)
      VER_MPEG1: begin
        unique case (sri)
          2'd0:    val = 16'd44100;
          2'd1:    val = 16'd48000;
          2'd2:    val = 16'd32000;
          default: val = '0;
        endcase
      end
      VER_MPEG2: begin
        unique case (sri)
          2'd0:    val = 16'd22050;
          2'd1:    val = 16'd24000;
          2'd2:    val = 16'd16000;
          default: val = '0;
        endcase
      end
      VER_MPEG25: begin
        unique case (sri)
          2'd0:    val = 16'd11025;
          2'd1:    val = 16'd12000;
          2'd2:    val = 16'd8000;
          default: val = '0;
        endcase
      end
      default: val = '0;
    endcase
    return val;
  endfunction

  // floor(2^32 / rate) for each defined rate; zero otherwise.
  function automatic logic [RECIP_W-1:0] recip_lookup(input logic [1:0] ver,
                                                      input logic [1:0] sri);
    logic [RECIP_W-1:0] val;
    val = '0;
    unique case (ver)
      VER_MPEG1: begin
        unique case (sri)
          2'd0:    val = 20'd97391;
          2'd1:    val = 20'd89478;
          2'd2:    val = 20'd134217;
          default: val = '0;
        endcase
      end
      VER_MPEG2: begin
        unique case (sri)
          2'd0:    val = 20'd194783;
          2'd1:    val = 20'd178956;
          2'd2:    val = 20'd268435;
          default: val = '0;
        endcase
      end
      VER_MPEG25: begin
        unique case (sri)
          2'd0:    val = 20'd389566;
          2'd1:    val = 20'd357913;
          2'd2:    val = 20'd536870;
          default: val = '0;
        endcase
      end
      default: val = '0;
    endcase
    return val;
  endfunction

  // PCM samples per frame from version and layer code.
  function automatic logic [SPF_W-1:0] spf_lookup(input logic [1:0] ver,
                                                  input logic [1:0] lay);
    logic [SPF_W-1:0] val;
    val = '0;
    if (ver != VER_RSV) begin
      unique case (lay)
        LAY_1:   val = 11'd384;
        LAY_2:   val = 11'd1152;
        LAY_3:   val = (ver == VER_MPEG1) ? 11'd1152 : 11'd576;
        default: val = '0;
      endcase
    end
    return val;
  endfunction

endpackage

/* rtl/core/mpeg_audio_frame_header_decode.sv */
// ----------------------------------------------------------------------------
// mpeg_audio_frame_header_decode
// Decodes one 32-bit MPEG audio frame header per request into validity,
// tables-derived rates, sample count and frame length in bytes.
//
//   Channel  Direction  Handshake            Payload
//   in       sink       in_valid / in_ready   header_word
//   out      source     out_valid / out_ready header_valid .. emphasis_code
//
// Five register stages; one request enters per cycle while the output
// flows and no full stage is held.
// The depth is set by the two multiplications of the reciprocal division.
// Reset clears only the stage valid bits; payload registers are not reset.
// A stage holds while the stage after it is full and stalled, so a bubble
// is filled even while the output waits.
// ----------------------------------------------------------------------------
module mpeg_audio_frame_header_decode (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] header_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        header_valid,
  output logic [1:0]  version_code,
  output logic [1:0]  layer_number,
  output logic [18:0] bitrate_bps,
  output logic [15:0] sample_rate_hz,
  output logic [10:0] frame_bytes,
  output logic [10:0] pcm_samples,
  output logic [1:0]  channel_count,
  output logic [2:0]  header_bytes,
  output logic [1:0]  channel_mode,
  output logic [2:0]  flag_bits,
  output logic [1:0]  emphasis_code
);
  import mafh_pkg::*;

  logic [NSTAGE-1:0] vld;
  logic [NSTAGE:0]   adv;
  ctl_t              ctl;
  dec_t              dec;
  info_t             info;

  // A stage may advance when it is empty or the stage after it advances.
  always_comb begin
    adv[NSTAGE] = out_ready;
    for (int i = NSTAGE - 1; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NSTAGE; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Payload load enables: load only when a request moves in.
  assign ctl.s1 = adv[0] && in_valid;
  assign ctl.s2 = adv[1] && vld[0];
  assign ctl.s3 = adv[2] && vld[1];
  assign ctl.s4 = adv[3] && vld[2];
  assign ctl.s5 = adv[4] && vld[3];

  assign in_ready  = adv[0];
  assign out_valid = vld[NSTAGE-1];

  mafh_decode u_decode (
    .clk         (clk),
    .load        (ctl.s1),
    .header_word (header_word),
    .dec         (dec)
  );

  mafh_frame_len u_frame_len (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .dec         (dec),
    .info        (info),
    .bitrate_bps (bitrate_bps),
    .frame_bytes (frame_bytes)
  );

  // Output field mapping.
  assign header_valid   = info.hdr_ok;
  assign version_code   = info.version_code;
  assign layer_number   = info.layer_number;
  assign sample_rate_hz = info.sample_rate_hz;
  assign pcm_samples    = info.pcm_samples;
  assign channel_count  = info.channel_count;
  assign header_bytes   = info.header_bytes;
  assign channel_mode   = info.channel_mode;
  assign flag_bits      = info.flag_bits;
  assign emphasis_code  = info.emphasis_code;

  // An empty output stage means the whole pipeline can take a request.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while the output stage is empty");

  a_rsv_version: assert property (@(posedge clk) disable iff (rst)
    out_valid && version_code == VER_RSV |->
      frame_bytes == '0 && bitrate_bps == '0 && sample_rate_hz == '0)
    else $error("reserved version produced nonzero rates");

  a_valid_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && header_valid |->
      frame_bytes != '0 && sample_rate_hz != '0 && layer_number != 2'd0)
    else $error("accepted header with undefined frame fields");

endmodule

/* rtl/core/mafh_decode.sv */
// ----------------------------------------------------------------------------
// mafh_decode
// First pipeline stage: splits the header word into fields, runs the
// validity checks and looks up bitrate, sample rate and frame constants.
// ----------------------------------------------------------------------------
module mafh_decode (
  input  logic          clk,
  input  logic          load,
  input  logic [31:0]   header_word,
  output mafh_pkg::dec_t dec
);
  import mafh_pkg::*;

  logic [1:0]  ver;
  logic [1:0]  lay;
  logic        prot;
  logic [3:0]  bri;
  logic [1:0]  sri;
  logic        pad;
  logic [1:0]  mode;
  logic        ver_ok;
  logic        lay_ok;
  logic [1:0]  layer_num;
  dec_t        dec_next;

  // Header field split.
  assign ver  = header_word[20:19];
  assign lay  = header_word[18:17];
  assign prot = header_word[16];
  assign bri  = header_word[15:12];
  assign sri  = header_word[11:10];
  assign pad  = header_word[9];
  assign mode = header_word[7:6];

  assign ver_ok    = (ver != VER_RSV);
  assign lay_ok    = (lay != LAY_RSV);
  // Layer number is 4 minus the code, which wraps to 0 for the reserved code.
  assign layer_num = 2'd0 - lay;

  // Table lookups and checks.
  always_comb begin
    dec_next = '0;
    dec_next.info.hdr_ok = (header_word[31:21] == SYNC_WORD) && ver_ok && lay_ok &&
                           (bri != 4'd0) && (bri != 4'd15) && (sri != 2'd3) &&
                           (ver == VER_MPEG1 || lay == LAY_3);
    dec_next.info.version_code   = ver;
    dec_next.info.layer_number   = layer_num;
    dec_next.info.sample_rate_hz = rate_lookup(ver, sri);
    dec_next.info.pcm_samples    = spf_lookup(ver, lay);
    dec_next.info.channel_count  = (mode == MODE_MONO) ? 2'd1 : 2'd2;
    dec_next.info.header_bytes   = prot ? 3'd4 : 3'd6;
    dec_next.info.channel_mode   = mode;
    dec_next.info.flag_bits      = {~prot, header_word[2], header_word[3]};
    dec_next.info.emphasis_code  = header_word[1:0];

    dec_next.kbps  = kbps_lookup(ver, lay, bri);
    dec_next.rate  = rate_lookup(ver, sri);
    dec_next.recip = recip_lookup(ver, sri);

    // The factor k, pre-scaled by 1000 to turn kbit/s into bit/s.
    if (lay == LAY_1) begin
      dec_next.kmul = 18'd48000;
    end else if (ver == VER_MPEG1) begin
      dec_next.kmul = 18'd144000;
    end else begin
      dec_next.kmul = 18'd72000;
    end

    // Padding adds a slot: four bytes in Layer I, one byte otherwise.
    if (pad) begin
      dec_next.padb = (lay == LAY_1) ? 3'd4 : 3'd1;
    end else begin
      dec_next.padb = 3'd0;
    end

    dec_next.frame_ok = ver_ok && lay_ok && (sri != 2'd3);
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (load) begin
      dec <= dec_next;
    end
  end

endmodule

/* rtl/core/mafh_frame_len.sv */
// ----------------------------------------------------------------------------
// mafh_frame_len
// Stages two to five: bitrate scaling, quotient estimate by reciprocal
// multiplication, remainder check and padding. Stage five is the output.
// ----------------------------------------------------------------------------
module mafh_frame_len (
  input  logic                   clk,
  input  logic                   rst,
  input  mafh_pkg::ctl_t         ctl,
  input  mafh_pkg::dec_t         dec,
  output mafh_pkg::info_t        info,
  output logic [mafh_pkg::BPS_W-1:0]   bitrate_bps,
  output logic [mafh_pkg::FRAME_W-1:0] frame_bytes
);
  import mafh_pkg::*;

  // Stage 2 registers.
  info_t              info2;
  logic [BPS_W-1:0]   bps2;
  logic [NUM_W-1:0]   num2;
  logic [RATE_W-1:0]  rate2;
  logic [RECIP_W-1:0] recip2;
  logic [2:0]         padb2;
  logic               ok2;
  // Stage 3 registers.
  info_t              info3;
  logic [BPS_W-1:0]   bps3;
  logic [NUM_W-1:0]   num3;
  logic [RATE_W-1:0]  rate3;
  logic [FRAME_W-1:0] qest3;
  logic [2:0]         padb3;
  logic               ok3;
  // Stage 4 registers.
  info_t              info4;
  logic [BPS_W-1:0]   bps4;
  logic [NUM_W-1:0]   num4;
  logic [RATE_W-1:0]  rate4;
  logic [FRAME_W-1:0] qest4;
  logic [QR_W-1:0]    qr4;
  logic [2:0]         padb4;
  logic               ok4;

  logic [KBPS_W+KMUL_W-1:0] num_full;
  logic [QPROD_W-1:0]       qprod;
  logic [NUM_W-1:0]         rem4;
  logic                     bump4;
  logic [FRAME_W-1:0]       frame_next;

  // Stage 2: bitrate in bit/s and the numerator k * bitrate.
  assign num_full = (KBPS_W+KMUL_W)'(dec.kbps) * (KBPS_W+KMUL_W)'(dec.kmul);

  always_ff @(posedge clk) begin
    if (ctl.s2) begin
      info2  <= dec.info;
      bps2   <= BPS_W'(dec.kbps) * BPS_W'(1000);
      num2   <= num_full[NUM_W-1:0];
      rate2  <= dec.rate;
      recip2 <= dec.recip;
      padb2  <= dec.padb;
      ok2    <= dec.frame_ok;
    end
  end

  // Stage 3: quotient estimate, low by at most one.
  assign qprod = QPROD_W'(num2) * QPROD_W'(recip2);

  always_ff @(posedge clk) begin
    if (ctl.s3) begin
      info3 <= info2;
      bps3  <= bps2;
      num3  <= num2;
      rate3 <= rate2;
      qest3 <= qprod[RECIP_SH +: FRAME_W];
      padb3 <= padb2;
      ok3   <= ok2;
    end
  end

  // Stage 4: multiply the estimate back by the rate.
  always_ff @(posedge clk) begin
    if (ctl.s4) begin
      info4 <= info3;
      bps4  <= bps3;
      num4  <= num3;
      rate4 <= rate3;
      qest4 <= qest3;
      qr4   <= QR_W'(qest3) * QR_W'(rate3);
      padb4 <= padb3;
      ok4   <= ok3;
    end
  end

  // Stage 5: remainder correction and padding.
  assign rem4       = num4 - qr4[NUM_W-1:0];
  assign bump4      = (rem4 >= NUM_W'(rate4));
  assign frame_next = ok4 ? (qest4 + FRAME_W'(bump4) + FRAME_W'(padb4)) : '0;

  always_ff @(posedge clk) begin
    if (ctl.s5) begin
      info        <= info4;
      bitrate_bps <= bps4;
      frame_bytes <= frame_next;
    end
  end

  // The reciprocal estimate never overshoots and is short by at most one.
  a_qest_low: assert property (@(posedge clk) disable iff (rst)
    ctl.s5 && ok4 |-> qr4[NUM_W-1:0] <= num4)
    else $error("frame length estimate above the true quotient");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    ctl.s5 && ok4 |-> rem4 < {rate4, 1'b0})
    else $error("frame length remainder needs more than one correction");

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the MPEG audio frame header decoder. A queue of header words
// (directed corner cases first, then random headers that are mostly
// well-formed) feeds a valid/ready driver. Every accepted request is decoded
// by an independent model in this file. Each result that leaves the block is
// compared field by field against the oldest decoded request. Both sides
// stall at random, and the stall rates change from phase to phase.
// ----------------------------------------------------------------------------
module tb_top;
  import mafh_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 12;

  // Expected decode of one header word.
  typedef struct packed {
    logic        hdr_ok;
    logic [1:0]  version;
    logic [1:0]  layer;
    logic [18:0] bps;
    logic [15:0] rate;
    logic [10:0] frame;
    logic [10:0] spf;
    logic [1:0]  chans;
    logic [2:0]  hbytes;
    logic [1:0]  mode;
    logic [2:0]  flags;
    logic [1:0]  emph;
  } header_fields_t;

  // Bitrates in kbit/s: rows V1 L1, V1 L2, V1 L3, V2 L1, V2 L2/L3.
  localparam logic [0:4][0:15][8:0] BITRATE_KBPS = {
    {9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
     9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
    {9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
     9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
    {9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
     9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0},
    {9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
     9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
    {9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
     9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
  };

  // MPEG-1 sample rates; MPEG-2 halves them and MPEG-2.5 quarters them.
  localparam logic [0:3][15:0] BASE_RATE_HZ = {16'd44100, 16'd48000, 16'd32000, 16'd0};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] header_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        header_valid;
  logic [1:0]  version_code;
  logic [1:0]  layer_number;
  logic [18:0] bitrate_bps;
  logic [15:0] sample_rate_hz;
  logic [10:0] frame_bytes;
  logic [10:0] pcm_samples;
  logic [1:0]  channel_count;
  logic [2:0]  header_bytes;
  logic [1:0]  channel_mode;
  logic [2:0]  flag_bits;
  logic [1:0]  emphasis_code;

  logic [31:0]    header_queue[$];
  header_fields_t pending_decodes[$];
  header_fields_t want;
  int             send_idle_pct = 0;
  int             recv_idle_pct = 0;
  int             fail_count = 0;
  int             cycle_count = 0;

  mpeg_audio_frame_header_decode u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .header_word(header_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .header_valid(header_valid),
    .version_code(version_code),
    .layer_number(layer_number),
    .bitrate_bps(bitrate_bps),
    .sample_rate_hz(sample_rate_hz),
    .frame_bytes(frame_bytes),
    .pcm_samples(pcm_samples),
    .channel_count(channel_count),
    .header_bytes(header_bytes),
    .channel_mode(channel_mode),
    .flag_bits(flag_bits),
    .emphasis_code(emphasis_code)
  );

  always #5 clk = ~clk;

  // Decodes a header word the way the block is expected to.
  function automatic header_fields_t decode_header(input logic [31:0] w);
    header_fields_t d;
    logic [1:0]  ver;
    logic [1:0]  lay;
    logic        ver_ok;
    logic        lay_ok;
    int unsigned layer_num;
    int unsigned row;
    int unsigned k;
    int unsigned padb;
    int unsigned bps;
    int unsigned rate;
    int unsigned frame;
    ver = w[20:19];
    lay = w[18:17];
    ver_ok = (ver != VER_RSV);
    lay_ok = (lay != LAY_RSV);
    layer_num = lay_ok ? 4 - int'(lay) : 0;
    bps = 0;
    rate = 0;
    frame = 0;

    if (ver_ok && lay_ok) begin
      if (ver == VER_MPEG1) row = layer_num - 1;
      else row = (layer_num == 1) ? 3 : 4;
      bps = BITRATE_KBPS[row][w[15:12]] * 1000;
    end

    if (ver == VER_MPEG1) rate = BASE_RATE_HZ[w[11:10]];
    else if (ver == VER_MPEG2) rate = BASE_RATE_HZ[w[11:10]] >> 1;
    else if (ver == VER_MPEG25) rate = BASE_RATE_HZ[w[11:10]] >> 2;

    // Frame length: floor(k * bitrate / rate) plus the padding slot.
    if (ver_ok && lay_ok && rate != 0) begin
      if (layer_num == 1) k = 48;
      else k = (ver == VER_MPEG1) ? 144 : 72;
      padb = w[9] ? ((layer_num == 1) ? 4 : 1) : 0;
      frame = (k * bps) / rate + padb;
    end

    d.hdr_ok = (w[31:21] == SYNC_WORD) && ver_ok && lay_ok
               && w[15:12] != 4'd0 && w[15:12] != 4'd15 && w[11:10] != 2'd3
               && (ver == VER_MPEG1 || lay == LAY_3);
    d.version = ver;
    d.layer = layer_num[1:0];
    d.bps = bps[18:0];
    d.rate = rate[15:0];
    d.frame = frame[10:0];
    d.spf = '0;
    if (ver_ok) begin
      if (lay == LAY_1) d.spf = 11'd384;
      else if (lay == LAY_2) d.spf = 11'd1152;
      else if (lay == LAY_3) d.spf = (ver == VER_MPEG1) ? 11'd1152 : 11'd576;
    end
    d.chans = (w[7:6] == MODE_MONO) ? 2'd1 : 2'd2;
    d.hbytes = w[16] ? 3'd4 : 3'd6;
    d.mode = w[7:6];
    d.flags = {~w[16], w[2], w[3]};
    d.emph = w[1:0];
    return d;
  endfunction

  // Builds a header with a good sync field; tail holds bits 8..0.
  function automatic logic [31:0] build_header(input logic [1:0] ver, input logic [1:0] lay,
                                               input logic prot, input logic [3:0] bri,
                                               input logic [1:0] sri, input logic pad,
                                               input logic [8:0] tail);
    return {SYNC_WORD, ver, lay, prot, bri, sri, pad, tail};
  endfunction

  // Mostly well-formed headers with random content, some with one field
  // broken, and some plain noise.
  function automatic logic [31:0] random_header();
    logic [31:0] w;
    int          pick;
    int          bit_pos;
    w = $urandom();
    pick = $urandom_range(0, 99);
    if (pick < 10) return w;
    w[31:21] = SYNC_WORD;
    case ($urandom_range(0, 3))
      0:       w[20:19] = VER_MPEG2;
      1:       w[20:19] = VER_MPEG25;
      default: w[20:19] = VER_MPEG1;
    endcase
    if (w[20:19] == VER_MPEG1) w[18:17] = 2'($urandom_range(1, 3));
    else w[18:17] = LAY_3;
    w[15:12] = 4'($urandom_range(1, 14));
    w[11:10] = 2'($urandom_range(0, 2));
    if (pick >= 75) begin
      case ($urandom_range(0, 5))
        0: w[20:19] = VER_RSV;
        1: w[18:17] = LAY_RSV;
        2: w[15:12] = $urandom_range(0, 1) ? 4'd15 : 4'd0;
        3: w[11:10] = 2'd3;
        4: begin
          w[20:19] = $urandom_range(0, 1) ? VER_MPEG2 : VER_MPEG25;
          w[18:17] = $urandom_range(0, 1) ? LAY_1 : LAY_2;
        end
        default: begin
          bit_pos = 21 + int'($urandom_range(0, 10));
          w[bit_pos] = ~w[bit_pos];
        end
      endcase
    end
    return w;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_val,
                             input int unsigned act_val);
    if (exp_val != act_val) begin
      fail_count++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_val, act_val);
    end
  endtask

  // Request driver: a new request goes out only once the current one is taken.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_ready) begin
        if (header_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          header_word <= header_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Monitor: decode each accepted request, check each accepted result.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) pending_decodes.push_back(decode_header(header_word));
      if (out_valid && out_ready) begin
        if (pending_decodes.size() == 0) begin
          fail_count++;
          $display("%0t: result with no request outstanding", $time);
        end else begin
          want = pending_decodes.pop_front();
          check_field("header_valid", want.hdr_ok, header_valid);
          check_field("version_code", want.version, version_code);
          check_field("layer_number", want.layer, layer_number);
          check_field("bitrate_bps", want.bps, bitrate_bps);
          check_field("sample_rate_hz", want.rate, sample_rate_hz);
          check_field("frame_bytes", want.frame, frame_bytes);
          check_field("pcm_samples", want.spf, pcm_samples);
          check_field("channel_count", want.chans, channel_count);
          check_field("header_bytes", want.hbytes, header_bytes);
          check_field("channel_mode", want.mode, channel_mode);
          check_field("flag_bits", want.flags, flag_bits);
          check_field("emphasis_code", want.emph, emphasis_code);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Stimulus sequence and end of test.
  initial begin
    // Directed corner cases.
    header_queue.push_back(32'h0000_0000);
    header_queue.push_back(32'hFFFF_FFFF);
    header_queue.push_back(build_header(VER_MPEG1, LAY_1, 1'b1, 4'd14, 2'd2, 1'b1, 9'h000));
    header_queue.push_back(build_header(VER_MPEG1, LAY_2, 1'b1, 4'd14, 2'd2, 1'b1, 9'h1FF));
    header_queue.push_back(build_header(VER_MPEG1, LAY_3, 1'b0, 4'd9, 2'd0, 1'b0, 9'h004));
    header_queue.push_back(build_header(VER_MPEG1, LAY_3, 1'b1, 4'd1, 2'd1, 1'b1, 9'h0C9));
    header_queue.push_back(build_header(VER_MPEG2, LAY_3, 1'b0, 4'd14, 2'd2, 1'b1, 9'h042));
    header_queue.push_back(build_header(VER_MPEG25, LAY_3, 1'b1, 4'd1, 2'd0, 1'b0, 9'h08B));
    header_queue.push_back(build_header(VER_MPEG25, LAY_3, 1'b1, 4'd14, 2'd2, 1'b1, 9'h133));
    header_queue.push_back(build_header(VER_MPEG2, LAY_1, 1'b1, 4'd14, 2'd1, 1'b1, 9'h000));
    header_queue.push_back(build_header(VER_MPEG2, LAY_2, 1'b0, 4'd5, 2'd0, 1'b0, 9'h0C0));
    header_queue.push_back(build_header(VER_MPEG25, LAY_1, 1'b1, 4'd14, 2'd2, 1'b1, 9'h001));
    // Reserved version, reserved layer and reserved rate index.
    header_queue.push_back(build_header(VER_RSV, LAY_3, 1'b1, 4'd9, 2'd0, 1'b1, 9'h000));
    header_queue.push_back(build_header(VER_MPEG1, LAY_RSV, 1'b1, 4'd9, 2'd1, 1'b1, 9'h000));
    header_queue.push_back(build_header(VER_MPEG25, LAY_RSV, 1'b0, 4'd3, 2'd3, 1'b0, 9'h002));
    header_queue.push_back(build_header(VER_MPEG1, LAY_3, 1'b1, 4'd9, 2'd3, 1'b1, 9'h000));
    // Free-format and bad bitrate indexes leave only the padding.
    header_queue.push_back(build_header(VER_MPEG1, LAY_2, 1'b1, 4'd0, 2'd0, 1'b1, 9'h000));
    header_queue.push_back(build_header(VER_MPEG1, LAY_1, 1'b1, 4'd15, 2'd0, 1'b1, 9'h000));
    header_queue.push_back(build_header(VER_MPEG2, LAY_3, 1'b1, 4'd15, 2'd1, 1'b0, 9'h000));
    // Broken sync at either end of the field.
    header_queue.push_back(build_header(VER_MPEG1, LAY_3, 1'b1, 4'd9, 2'd0, 1'b0, 9'h000)
                           ^ 32'h0020_0000);
    header_queue.push_back(build_header(VER_MPEG1, LAY_3, 1'b1, 4'd9, 2'd0, 1'b0, 9'h000)
                           ^ 32'h8000_0000);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Three random phases; between them the sender holds off until all
    // outstanding results have come back.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 37;
          recv_idle_pct = 63;
        end
        1: begin
          send_idle_pct = 63;
          recv_idle_pct = 37;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      repeat (200) header_queue.push_back(random_header());
      do @(negedge clk);
      while (header_queue.size() != 0 || in_valid || pending_decodes.size() != 0);
    end

    // Let any stray result show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* mpeg_audio_frame_header_decode.f */
rtl/core/mafh_pkg.sv
rtl/core/mafh_decode.sv
rtl/core/mafh_frame_len.sv
rtl/core/mpeg_audio_frame_header_decode.sv
test/tb_top.sv
